@@ src/pei_pkg.sv @@
// Shared types and constants for the piecewise exponential inverse sampler.
package pei_pkg;

  // Table geometry and fixed-point format.
  localparam int MAX_INTERVALS = 16;
  localparam int IDX_W         = 4;
  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS     = 16;
  localparam int DIV_BITS      = WORD_BITS + FRAC_BITS;
  localparam int COUNT_W       = 5;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  // Register map, indexed by word address.
  localparam logic REG_INTERVAL_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

  // Command codes of an input item.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [IDX_W-1:0]     entry_index;
    logic [WORD_BITS-1:0] entry_start_time;
    logic [WORD_BITS-1:0] entry_cum_hazard;
    logic [WORD_BITS-1:0] entry_rate;
    logic [WORD_BITS-1:0] variate;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] event_time;
    logic [IDX_W-1:0]     interval_found;
    logic                 saturated;
  } out_item_t;

  // One table entry as stored in the interval memory.
  typedef struct packed {
    logic [WORD_BITS-1:0] start_time;
    logic [WORD_BITS-1:0] cum_hazard;
    logic [WORD_BITS-1:0] rate;
  } entry_t;

  // Result of the fixed-point divider.
  typedef struct packed {
    logic                 ovf;
    logic [WORD_BITS-1:0] quot;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FIX,
    ST_LOAD,
    ST_DIV,
    ST_SUM
  } state_t;

endpackage

@@ src/piecewise_exponential_inverse_sampler.sv @@
// Top level of the piecewise exponential inverse cumulative hazard sampler.
//
//   Channel  Direction  Transfer when          Payload
//   in_      input      in_valid & in_ready    pei_pkg::in_item_t
//   out_     output     out_valid & out_ready  pei_pkg::out_item_t
//   APB      input      psel&penable&pwrite    interval_count at address 0
//
// A load item writes the interval memory directly and leaves the block idle for the next item.
// A sample item runs a binary search (at most four steps, each a probe and a compare),
// fetches the chosen entry, runs the bit-serial divider, adds in SUM and returns to idle;
// SUM holds while the output register is full and not taken, and no item is taken until idle.
// Reset clears the control state and sets interval_count to 1; the memory is not cleared.
// A result waits in the output register while the next item is taken.
module piecewise_exponential_inverse_sampler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pei_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pei_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pei_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pei_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pei_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pei_pkg::*;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]     lo_r, lo_nxt;
  logic [IDX_W-1:0]     hi_r, hi_nxt;
  logic [WORD_BITS-1:0] tgt_r, tgt_nxt;
  logic [WORD_BITS-1:0] start_r, start_nxt;
  logic                 rzero_r, rzero_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 in_xfer;
  logic                 cfg_wr;
  logic [IDX_W:0]       mid_sum;
  logic [IDX_W-1:0]     mid;
  logic [IDX_W-1:0]     hi_init;
  logic                 step_back;
  logic                 take_entry;
  logic                 out_free;
  logic [WORD_BITS-1:0] excess;
  logic [WORD_BITS:0]   sum;
  logic                 sat;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t               wr_entry;
  entry_t               rd_entry;

  logic                 div_start;
  logic                 div_done;
  div_res_t             div_res;

  // Configuration register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_INTERVAL_COUNT)) begin
      count_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_INTERVAL_COUNT) begin
      prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, count_r};
    end
  end

  // Interval memory: one word holds start time, cumulative hazard and rate.
  assign wr_entry.start_time = in_data.entry_start_time;
  assign wr_entry.cum_hazard = in_data.entry_cum_hazard;
  assign wr_entry.rate       = in_data.entry_rate;
  assign rd_entry            = entry_t'(ram_rdata);

  pei_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_INTERVALS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.entry_index),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Search helpers: midpoint, clamped upper bound, step back past a too-large entry.
  assign in_xfer    = in_valid && in_ready;
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[IDX_W:1];
  assign step_back  = (rd_entry.cum_hazard > tgt_r) && (lo_r != '0);
  assign take_entry = ((state_r == ST_FIX) && !step_back) || (state_r == ST_LOAD);
  assign excess     = (tgt_r >= rd_entry.cum_hazard) ? (tgt_r - rd_entry.cum_hazard) : '0;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    if (count_r == '0) begin
      hi_init = '0;
    end else if (count_r > COUNT_W'(MAX_INTERVALS)) begin
      hi_init = IDX_W'(MAX_INTERVALS - 1);
    end else begin
      hi_init = IDX_W'(count_r - 1'b1);
    end
  end

  pei_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (excess),
    .den   (rd_entry.rate),
    .done  (div_done),
    .res   (div_res)
  );

  // Final add with saturation on zero rate, quotient overflow or carry out.
  assign sum = {1'b0, start_r} + {1'b0, div_res.quot};
  assign sat = rzero_r || div_res.ovf || sum[WORD_BITS];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.cmd == CMD_SAMPLE)) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_nxt = (lo_r < hi_r) ? ST_CMP : ST_FIX;
      end
      ST_CMP: begin
        state_nxt = ST_PROBE;
      end
      ST_FIX: begin
        state_nxt = step_back ? ST_LOAD : ST_DIV;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs: handshake, memory ports and divider start.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = lo_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_valid && (in_data.cmd == CMD_LOAD);
      end
      ST_PROBE: begin
        ram_raddr = (lo_r < hi_r) ? mid : lo_r;
      end
      ST_FIX: begin
        ram_raddr = lo_r - 1'b1;
        div_start = take_entry;
      end
      ST_LOAD: begin
        div_start = 1'b1;
      end
      default: begin
        ram_raddr = lo_r;
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    tgt_nxt       = tgt_r;
    start_nxt     = start_r;
    rzero_nxt     = rzero_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if ((state_r == ST_IDLE) && in_xfer) begin
      lo_nxt  = '0;
      hi_nxt  = hi_init;
      tgt_nxt = in_data.variate;
    end
    if (state_r == ST_CMP) begin
      if (rd_entry.cum_hazard <= tgt_r) begin
        lo_nxt = mid + 1'b1;
      end else begin
        hi_nxt = mid;
      end
    end
    if ((state_r == ST_FIX) && step_back) begin
      lo_nxt = lo_r - 1'b1;
    end
    if (take_entry) begin
      start_nxt = rd_entry.start_time;
      rzero_nxt = (rd_entry.rate == '0);
    end
    if ((state_r == ST_SUM) && out_free) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.event_time     = sat ? {WORD_BITS{1'b1}} : sum[WORD_BITS-1:0];
      out_data_nxt.interval_found = lo_r;
      out_data_nxt.saturated      = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    tgt_r      <= tgt_nxt;
    start_r    <= start_nxt;
    rzero_r    <= rzero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/pei_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pei_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/pei_divider.sv @@
// Restoring divider for (num * 2^FRAC_BITS) / den, one quotient bit per cycle.
module pei_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pei_pkg::WORD_BITS-1:0] num,
  input  logic [pei_pkg::WORD_BITS-1:0] den,
  output logic                          done,
  output pei_pkg::div_res_t             res
);
  import pei_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS);

  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]  dvd_r, dvd_nxt;
  logic [DIV_BITS-1:0]  quo_r, quo_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] den_r, den_nxt;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   diff;
  logic                 ge;

  // Shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_r, dvd_r[DIV_BITS-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_BITS - 1);
      dvd_nxt  = {num, {FRAC_BITS{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
      quo_nxt = {quo_r[DIV_BITS-2:0], ge};
      dvd_nxt = {dvd_r[DIV_BITS-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // The last step is taken at the edge where done is high.
  assign done     = busy_r && (cnt_r == '0);
  assign res.quot = quo_r[WORD_BITS-1:0];
  assign res.ovf  = |quo_r[DIV_BITS-1:WORD_BITS];

endmodule

@@ tb/pei_result_checker.sv @@
// Checker for the sampler: watches all three ports, predicts each sample and compares results.
module pei_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  pei_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  pei_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [pei_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pei_pkg::APB_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             pending
);
  import pei_pkg::*;

  localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(4 * REG_INTERVAL_COUNT);
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the interval table and the count register.
  logic [WORD_BITS-1:0] start_tab [MAX_INTERVALS];
  logic [WORD_BITS-1:0] cum_tab   [MAX_INTERVALS];
  logic [WORD_BITS-1:0] rate_tab  [MAX_INTERVALS];
  logic [COUNT_W-1:0]   search_count;

  out_item_t expected_events [$];
  int        mismatch_count;

  initial begin
    fail_count     = 0;
    pending        = 0;
    mismatch_count = 0;
    search_count   = COUNT_RESET;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      start_tab[i] = '0;
      cum_tab[i]   = '0;
      rate_tab[i]  = '0;
    end
  end

  // Search the table for the interval of variate v and invert its hazard.
  function automatic out_item_t predict_event(input logic [WORD_BITS-1:0] v);
    int unsigned          n;
    int unsigned          lo;
    int unsigned          hi;
    int unsigned          mid;
    int unsigned          k;
    int                   i;
    logic [WORD_BITS-1:0] excess;
    logic [WORD_BITS-1:0] quot;
    logic [63:0]          rem;
    logic [WORD_BITS:0]   total;
    logic                 sat;
    logic                 next_bit;
    logic                 carry;
    out_item_t            res;
    n = (search_count == 0) ? 1 :
        ((search_count > MAX_INTERVALS) ? MAX_INTERVALS : search_count);
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (cum_tab[mid] <= v) lo = mid + 1;
      else hi = mid;
    end
    k = lo;
    if (cum_tab[k] > v && k > 0) k = k - 1;
    // A variate below the interval's hazard counts as zero excess.
    excess = (v >= cum_tab[k]) ? v - cum_tab[k] : '0;
    sat    = 1'b0;
    total  = '0;
    if (rate_tab[k] == 0) begin
      sat = 1'b1;
    end else begin
      // Restoring long division of excess * 2^FRAC_BITS by the rate.
      rem  = '0;
      quot = '0;
      i    = DIV_BITS - 1;
      while (i >= 0 && !sat) begin
        next_bit = (i >= FRAC_BITS) ? excess[i-FRAC_BITS] : 1'b0;
        carry    = rem[63];
        rem      = {rem[62:0], next_bit};
        if (quot[WORD_BITS-1]) begin
          sat = 1'b1;
        end else begin
          quot = quot << 1;
          if (carry || rem >= {32'b0, rate_tab[k]}) begin
            rem     = rem - {32'b0, rate_tab[k]};
            quot[0] = 1'b1;
          end
        end
        i = i - 1;
      end
      if (!sat) begin
        total = {1'b0, start_tab[k]} + {1'b0, quot};
        if (total[WORD_BITS]) sat = 1'b1;
      end
    end
    res.event_time     = sat ? '1 : total[WORD_BITS-1:0];
    res.interval_found = k[IDX_W-1:0];
    res.saturated      = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      search_count = COUNT_RESET;
      expected_events.delete();
    end else begin
      // Result transfer: compare with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: time=%h k=%0d sat=%b",
                     out_data.event_time, out_data.interval_found, out_data.saturated);
        end else begin
          want = expected_events.pop_front();
          bad  = (out_data.event_time !== want.event_time) ||
                 (out_data.interval_found !== want.interval_found) ||
                 (out_data.saturated !== want.saturated);
          if (bad) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: expected time=%h k=%0d sat=%b, got time=%h k=%0d sat=%b",
                       want.event_time, want.interval_found, want.saturated,
                       out_data.event_time, out_data.interval_found, out_data.saturated);
          end
        end
      end
      // Input transfer: a load updates the table, a sample is predicted.
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_LOAD) begin
          start_tab[in_data.entry_index] = in_data.entry_start_time;
          cum_tab[in_data.entry_index]   = in_data.entry_cum_hazard;
          rate_tab[in_data.entry_index]  = in_data.entry_rate;
        end else begin
          expected_events.push_back(predict_event(in_data.variate));
        end
      end
      // Register write on the access phase.
      if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
        search_count = pwdata[COUNT_W-1:0];
    end
    fail_count <= mismatch_count;
    pending    <= expected_events.size();
  end

endmodule

@@ tb/tb_piecewise_exponential_inverse_sampler.sv @@
// Testbench top for the sampler: reset, directed and random stimulus, and the final verdict.
module tb_piecewise_exponential_inverse_sampler;
  import pei_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_CYCLES  = 200;
  localparam int PHASE_ITEMS   = 140;
  localparam int PHASES        = 12;
  localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(4 * REG_INTERVAL_COUNT);

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_item_t             out_data;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                   send_idle_pct = 31;
  int                   recv_idle_pct = 54;
  int                   items_sent    = 0;
  int                   cycles        = 0;
  int                   fail_count;
  int                   pending;
  logic [WORD_BITS-1:0] hazard_top    = '0;

  piecewise_exponential_inverse_sampler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pei_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random according to the current mode.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [WORD_BITS-1:0] clamp_word(input logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? '1 : x[WORD_BITS-1:0];
  endfunction

  // Unused fields of an item carry random content.
  function automatic in_item_t load_item(input logic [IDX_W-1:0] idx,
                                         input logic [WORD_BITS-1:0] st,
                                         input logic [WORD_BITS-1:0] cum,
                                         input logic [WORD_BITS-1:0] rate);
    in_item_t it;
    it.cmd              = CMD_LOAD;
    it.entry_index      = idx;
    it.entry_start_time = st;
    it.entry_cum_hazard = cum;
    it.entry_rate       = rate;
    it.variate          = $urandom;
    return it;
  endfunction

  function automatic in_item_t sample_item(input logic [WORD_BITS-1:0] v);
    in_item_t it;
    it.cmd              = CMD_SAMPLE;
    it.entry_index      = IDX_W'($urandom);
    it.entry_start_time = $urandom;
    it.entry_cum_hazard = $urandom;
    it.entry_rate       = $urandom;
    it.variate          = v;
    return it;
  endfunction

  // Mostly moderate rates, with zero, tiny and huge ones mixed in.
  function automatic logic [WORD_BITS-1:0] pick_rate();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(32'h0000_1000, 32'h0004_0000);
    else if (roll < 87) return '0;
    else if (roll < 94) return $urandom_range(1, 255);
    else return $urandom;
  endfunction

  // Present one item and hold it until the transfer.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
  endtask

  // Let every outstanding sample finish and the block go quiet.
  task automatic wait_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access phases; upper data bits are sometimes random.
  task automatic write_count(input logic [COUNT_W-1:0] c);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= {($urandom_range(1) != 0) ? 27'($urandom) : 27'd0, c};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Load a sorted table over the first n entries.
  task automatic rebuild_table(input int n);
    logic [63:0] cum_acc;
    logic [63:0] st_acc;
    cum_acc = ($urandom_range(99) < 75) ? 64'd0 : 64'($urandom_range(0, 32'h2_0000));
    st_acc  = ($urandom_range(99) < 90) ? 64'($urandom_range(0, 32'h10_0000))
                                        : 64'($urandom);
    for (int i = 0; i < n; i++) begin
      send_item(load_item(IDX_W'(i), clamp_word(st_acc), clamp_word(cum_acc), pick_rate()));
      hazard_top = clamp_word(cum_acc);
      if ($urandom_range(99) >= 10) cum_acc = cum_acc + $urandom_range(1, 32'h4_0000);
      st_acc = st_acc + $urandom_range(0, 32'h8_0000);
    end
  endtask

  // Variates mostly within the table's hazard span, some anywhere.
  task automatic draw_samples(input int m);
    logic [WORD_BITS-1:0] span;
    span = clamp_word(64'(hazard_top) + 64'h4_0000);
    repeat (m) begin
      if ($urandom_range(99) < 80) send_item(sample_item($urandom_range(0, span)));
      else send_item(sample_item($urandom));
    end
  endtask

  initial begin
    int unsigned count_plan [PHASES];
    int          n_eff;
    int          phase_start;
    int          roll;

    count_plan = '{16, 1, 0, 0, 31, 17, 0, 16, 0, 1, 16, 0};
    count_plan[3]  = $urandom_range(2, 15);
    count_plan[6]  = $urandom_range(2, 15);
    count_plan[8]  = $urandom_range(2, 15);
    count_plan[11] = $urandom_range(2, 15);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: starts 16.0 apart, hazards 1.0, 3.0, 5.0 and so on, unit rates,
    // with a zero rate, a tiny rate, a full-scale rate and a top start time.
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      logic [WORD_BITS-1:0] st;
      logic [WORD_BITS-1:0] rate;
      st   = (i == 15) ? '1 : WORD_BITS'(i << 20);
      rate = (i == 5) ? '0 : (i == 9) ? 32'd1 : (i == 12) ? '1 : 32'h0001_0000;
      send_item(load_item(IDX_W'(i), st, WORD_BITS'((2 * i + 1) << 16), rate));
    end
    hazard_top = 32'd31 << 16;
    wait_settle();
    write_count(5'd16);

    // Below the first hazard, an exact hazard hit, zero rate, a second exact hazard hit,
    // full-scale rate, exact top entry, sum overflow, and an ordinary interval.
    send_item(sample_item(32'h0000_0000));
    send_item(sample_item(32'h0007_0000));
    send_item(sample_item(32'h000B_8000));
    send_item(sample_item(32'h0015_0000));
    send_item(sample_item(32'h0019_1234));
    send_item(sample_item(32'h001F_0000));
    send_item(sample_item(32'hFFFF_FFFF));
    send_item(sample_item(32'h0005_4000));

    // Random phases under each idling mode and several counts.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_settle();
      case (ph / 4)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_count(COUNT_W'(count_plan[ph]));
      n_eff = (count_plan[ph] == 0) ? 1 :
              ((count_plan[ph] > MAX_INTERVALS) ? MAX_INTERVALS : count_plan[ph]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          rebuild_table(n_eff);
          draw_samples($urandom_range(4, 16));
        end else if (roll < 85) begin
          // Scattered writes break the ordering of the table.
          repeat ($urandom_range(1, 3))
            send_item(load_item(IDX_W'($urandom), $urandom, $urandom, $urandom));
          draw_samples($urandom_range(2, 6));
        end else begin
          repeat ($urandom_range(3, 8)) send_item(sample_item($urandom));
        end
      end
    end

    // Drain the remaining results, then give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
